/* design/adc_sample_frame_parser_core_assert.svh */
// assertion macros used by the checker
`ifndef ADC_SAMPLE_FRAME_PARSER_CORE_ASSERT_SVH
`define ADC_SAMPLE_FRAME_PARSER_CORE_ASSERT_SVH

// clocked check, quiet while reset is asserted
`define AFP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("afp assertion failed");

// clocked check that also holds during reset
`define AFP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("afp assertion failed");

`endif

/* design/afp_pkg.sv */
`timescale 1ns / 1ps

package afp_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int CH_IDX_W     = $clog2(MAX_CHANNELS);
  localparam int SAMPLE_W     = 24;
  localparam int STATUS_W     = 24;
  localparam int PARTIAL_W    = 16;
  localparam int BYTE_W       = 8;
  localparam int OFFSET_W     = 5;
  localparam int GROUP_W      = 4;
  localparam int ERR_W        = 2;
  localparam int TDATA_W      = 224;
  localparam int PAD_W        = TDATA_W - (STATUS_W + ERR_W + MAX_CHANNELS * SAMPLE_W);

  localparam logic [BYTE_W-1:0] HDR_MASK  = 8'hF0;
  localparam logic [BYTE_W-1:0] HDR_VALUE = 8'hC0;

  // position of a byte inside its 24-bit sample
  localparam logic [1:0] PHASE_HI  = 2'd0;
  localparam logic [1:0] PHASE_MID = 2'd1;
  localparam logic [1:0] PHASE_LO  = 2'd2;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK      = 2'd0,
    ERR_HEADER  = 2'd1,
    ERR_ZERO_CH = 2'd2
  } err_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic                start_of_frame;
    logic [BYTE_W-1:0]   data_byte;
  } in_item_t;

  // laid out exactly as the output tdata, last field lowest
  typedef struct packed {
    logic [PAD_W-1:0]              pad;
    sample_t [MAX_CHANNELS-1:0]    sample;
    err_e                          error_code;
    logic [STATUS_W-1:0]           status_word;
  } result_t;

  // v / 3 for v below 32
  function automatic logic [GROUP_W-1:0] div3(input logic [OFFSET_W-1:0] v);
    logic [OFFSET_W+3:0] prod;
    prod = (OFFSET_W+4)'(v) * (OFFSET_W+4)'(11);
    return prod[OFFSET_W+3:OFFSET_W];
  endfunction

endpackage

/* design/afp_in_reg.sv */
`timescale 1ns / 1ps

module afp_in_reg
  import afp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  in_item_t item_i,
  input  logic     advance_i,
  output logic     valid_o,
  output in_item_t item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  assign ready_o = !valid_q || advance_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* design/afp_frame_parse.sv */
`timescale 1ns / 1ps

module afp_frame_parse
  import afp_pkg::*;
#(
  parameter int NUM_CHANNELS = 8,
  parameter int STATUS_BYTES = 3
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  in_item_t item_i,
  output logic     last_o,
  output result_t  result_o
);

  localparam int FrameBytes = STATUS_BYTES + 3 * NUM_CHANNELS;
  localparam int PosW       = $clog2(FrameBytes + 1);

  logic [PosW-1:0]                        pos_q, pos_d, pos;
  logic [STATUS_W-1:0]                    status_q, status_d;
  logic [PARTIAL_W-1:0]                   partial_q, partial_d;
  logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0]  store_q, store_d;
  logic                                   hdr_bad_q, hdr_bad_d;
  logic [OFFSET_W-1:0]                    offset;
  logic [GROUP_W-1:0]                     group;
  logic [1:0]                             phase;
  logic [BYTE_W-1:0]                      b;
  err_e                                   err;

  assign b = item_i.data_byte;

  always_comb begin
    pos = pos_q;
    if (item_i.start_of_frame || pos_q >= PosW'(FrameBytes)) begin
      pos = '0;
    end
  end

  assign last_o = (pos == PosW'(FrameBytes - 1));

  always_comb begin
    status_d  = status_q;
    partial_d = partial_q;
    store_d   = store_q;
    hdr_bad_d = hdr_bad_q;
    offset    = '0;
    group     = '0;
    phase     = PHASE_HI;
    pos_d     = last_o ? '0 : pos + PosW'(1);
    if (pos < PosW'(STATUS_BYTES)) begin
      if (pos == '0) begin
        status_d  = {{(STATUS_W - BYTE_W){1'b0}}, b};
        hdr_bad_d = ((b & HDR_MASK) != HDR_VALUE);
      end else begin
        status_d = {status_q[STATUS_W-BYTE_W-1:0], b};
      end
    end else begin
      offset = OFFSET_W'(pos - PosW'(STATUS_BYTES));
      group  = div3(offset);
      phase  = 2'(offset - {group, 1'b0} - OFFSET_W'(group));
      case (phase)
        PHASE_HI: begin
          partial_d = {{(PARTIAL_W - BYTE_W){1'b0}}, b};
        end
        PHASE_MID: begin
          partial_d = {partial_q[PARTIAL_W-BYTE_W-1:0], b};
        end
        PHASE_LO: begin
          if (group < GROUP_W'(MAX_CHANNELS)) begin
            store_d[group[CH_IDX_W-1:0]] = {partial_q, b};
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (hdr_bad_d) begin
      err = ERR_HEADER;
    end else if (store_d[0] == '0) begin
      err = ERR_ZERO_CH;
    end else begin
      err = ERR_OK;
    end
    result_o             = '0;
    result_o.status_word = status_d;
    result_o.error_code  = err;
    for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
      if (err == ERR_OK && ch < NUM_CHANNELS) begin
        result_o.sample[ch] = store_d[ch];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      status_q  <= '0;
      partial_q <= '0;
      store_q   <= '0;
      hdr_bad_q <= 1'b0;
    end else if (fire_i) begin
      pos_q     <= pos_d;
      status_q  <= status_d;
      partial_q <= partial_d;
      store_q   <= store_d;
      hdr_bad_q <= hdr_bad_d;
    end
  end

endmodule

/* design/afp_out_reg.sv */
`timescale 1ns / 1ps

module afp_out_reg
  import afp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t result_i,
  output logic    ready_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

/* design/adc_sample_frame_parser_core.sv */
`timescale 1ns / 1ps

// Converter frame parser. Takes one byte per cycle from a frame of
// STATUS_BYTES status bytes followed by NUM_CHANNELS 24-bit big-endian
// samples, and on the frame's last byte returns one item with the status
// word, an error code (0 ok, 1 top nibble of the first byte is not 0xC,
// 2 channel one all zero) and the eight samples, all zero on error or
// beyond NUM_CHANNELS. A byte with tuser high restarts the frame at the
// first status byte; frames may otherwise follow back to back. Every byte
// passes an input register and then a single parse step into the result
// register, so a byte can be accepted in every cycle as long as the result
// side keeps up; a result is registered as its last byte leaves the
// input register; while it waits, bytes of the next frame keep flowing in.
module adc_sample_frame_parser_core
  import afp_pkg::*;
#(
  parameter int NUM_CHANNELS = 8,
  parameter int STATUS_BYTES = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,   // data_byte
  input  logic               s_axis_tuser_i,   // start_of_frame
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // status_word, error_code, sample_ch0 .. sample_ch7, zero pad
  output logic [TDATA_W-1:0] m_axis_tdata_o
);

  in_item_t in_item, held_item;
  logic     held_valid;
  logic     last;
  logic     out_ready;
  logic     advance;
  result_t  frame_result, out_result;

  assign in_item.data_byte      = s_axis_tdata_i;
  assign in_item.start_of_frame = s_axis_tuser_i;

  assign advance = held_valid && (!last || out_ready);

  afp_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .ready_o   (s_axis_tready_o),
    .item_i    (in_item),
    .advance_i (advance),
    .valid_o   (held_valid),
    .item_o    (held_item)
  );

  afp_frame_parse #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .STATUS_BYTES (STATUS_BYTES)
  ) u_frame_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (held_item),
    .last_o   (last),
    .result_o (frame_result)
  );

  afp_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (advance && last),
    .result_i (frame_result),
    .ready_o  (out_ready),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .result_o (out_result)
  );

  assign m_axis_tdata_o = out_result;

endmodule

/* design/afp_checker.sv */
`timescale 1ns / 1ps

`include "adc_sample_frame_parser_core_assert.svh"

module afp_checker
  import afp_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               m_axis_tvalid_o,
  input logic               m_axis_tready_i,
  input logic [TDATA_W-1:0] m_axis_tdata_o
);

  result_t res;

  assign res = m_axis_tdata_o;

  `AFP_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
  `AFP_ASSERT(a_err_code, m_axis_tvalid_o |-> (res.error_code == ERR_OK
    || res.error_code == ERR_HEADER || res.error_code == ERR_ZERO_CH))
  `AFP_ASSERT(a_err_zero, m_axis_tvalid_o && res.error_code != ERR_OK
    |-> res.sample == '0 && res.pad == '0)
  `AFP_ASSERT(a_ok_ch0, m_axis_tvalid_o && res.error_code == ERR_OK
    |-> res.sample[0] != '0 && res.pad == '0)
  `AFP_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> !m_axis_tvalid_o)

endmodule

bind adc_sample_frame_parser_core afp_checker u_afp_checker (.*);
